// File: design/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg
// Shared field widths and result event codes of the order book matcher.
// ---------------------------------------------------------------------------
package lobm_pkg;

  localparam int EV_W    = 3;
  localparam int OID_W   = 16;
  localparam int QTY_W   = 16;
  localparam int PRICE_W = 8;

  localparam logic [EV_W-1:0] EV_TRADE     = 3'd0;
  localparam logic [EV_W-1:0] EV_RESTED    = 3'd1;
  localparam logic [EV_W-1:0] EV_CANCELLED = 3'd2;
  localparam logic [EV_W-1:0] EV_UNKNOWN   = 3'd3;
  localparam logic [EV_W-1:0] EV_DROPPED   = 3'd4;

  localparam logic KIND_NEW    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

endpackage

// File: design/lobm_level_store.sv
// ---------------------------------------------------------------------------
// lobm_level_store
// Price level memory (head, tail, volume per side and price). One write and
// one registered read port. After reset a sweep zeroes every entry.
// ---------------------------------------------------------------------------
module lobm_level_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          busy_r;
  logic [DW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_q_r;

endmodule

// File: design/limit_order_book_matcher.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book with matching.
//
// Input channel (in_*): one beat is a new limit order or a cancel by id.
// Result channel (out_*): one beat per trade, rest, cancel, unknown cancel or
// drop; out_last marks the final beat of an input. A zero-quantity order is
// consumed and yields no beat.
// An input is taken only while the engine is idle. Work runs on two memories
// with registered reads: the order slot memory and the price level memory.
// A trade reads the best opposite level, then its head slot, then emits; when
// the maker is filled it is unlinked from its level. After the last trade
// check a rest takes a free slot, links it at the level tail and emits, and a
// drop (no free slot) emits. A cancel scans the slots one by one, up to
// ORDER_SLOTS of them, then emits and unlinks. Emptying a best level rescans
// prices toward worse ones. After reset the level memory is cleared, during
// which in_ready is low. Results go through one output register; when the
// receiver stalls, the engine stalls at its next result.
// ---------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 32,
  parameter int ID_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic        in_side,
  input  logic [7:0]  in_limit_price,
  input  logic [15:0] in_quantity,
  input  logic [15:0] in_cancel_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_taker_id,
  output logic [15:0] out_maker_id,
  output logic [7:0]  out_price_out,
  output logic [15:0] out_quantity_out,
  output logic        out_last
);

  localparam int OW    = lobm_pkg::OID_W;
  localparam int QW    = lobm_pkg::QTY_W;
  localparam int PXW   = lobm_pkg::PRICE_W;
  localparam int EW    = lobm_pkg::EV_W;
  localparam int SW    = $clog2(ORDER_SLOTS);
  localparam int PW    = $clog2(PRICE_LEVELS);
  localparam int LD    = 2 * PRICE_LEVELS;
  localparam int LW    = $clog2(LD);
  localparam int VW    = QW + SW;
  localparam int CW    = (ID_BITS > OW) ? ID_BITS : OW;
  localparam int LEW   = 2 * SW + VW;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [QW-1:0]      qty;
    logic [PW-1:0]      price;
    logic               side;
    logic [SW-1:0]      nxt;
    logic [SW-1:0]      prv;
  } slot_t;

  typedef struct packed {
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [VW-1:0] vol;
  } level_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_C_RD, ST_C_CK, ST_C_EM, ST_C_MISS,
    ST_M_CHK, ST_M_LV, ST_M_SL, ST_M_TRD,
    ST_U_RD, ST_U_L, ST_U_PV, ST_U_NXRD, ST_U_NX, ST_U_BEST,
    ST_RS_RD, ST_RS_CHK,
    ST_P_FREE, ST_P_L, ST_P_T, ST_P_EM, ST_P_DROP
  } state_t;

  function automatic logic [LW-1:0] lvl_idx(input logic sd, input logic [PW-1:0] p);
    return sd ? (LW'(PRICE_LEVELS) + LW'(p)) : LW'(p);
  endfunction

  state_t             state_r;
  logic [ID_BITS-1:0] next_id_r;
  logic [ID_BITS-1:0] id_r;
  logic [ORDER_SLOTS-1:0] valid_r;
  logic [PW-1:0]      best_bid_r;
  logic [PW-1:0]      best_ask_r;
  logic               side_r;
  logic [PW-1:0]      price_r;
  logic [QW-1:0]      rem_r;
  logic [OW-1:0]      cid_r;
  logic [SW-1:0]      scan_r;
  logic [SW-1:0]      u_s_r;
  logic [SW-1:0]      t_r;
  logic [LW-1:0]      l_r;
  slot_t              sd_r;
  level_t             ld_r;
  logic               ret_match_r;
  logic               tail_is_r;
  logic               vol_zero_r;
  logic               rs_side_r;
  logic [PW-1:0]      rs_p_r;

  logic               out_valid_r;
  logic [EW-1:0]      out_ev_r;
  logic [OW-1:0]      out_taker_r;
  logic [OW-1:0]      out_maker_r;
  logic [PXW-1:0]     out_price_r;
  logic [QW-1:0]      out_qty_r;
  logic               out_last_r;

  slot_t              slot_mem [ORDER_SLOTS];
  slot_t              slot_q;
  logic               slot_we;
  logic [SW-1:0]      slot_wa;
  slot_t              slot_wd;
  logic [SW-1:0]      slot_ra;

  logic               lvl_busy;
  logic               lvl_we;
  logic [LW-1:0]      lvl_wa;
  level_t             lvl_wd;
  logic [LW-1:0]      lvl_ra;
  logic [LEW-1:0]     lvl_rd_raw;
  level_t             lq;

  logic               out_free;
  logic               emit_c;
  logic [PW-1:0]      bp;
  logic               no_cross;
  logic [QW-1:0]      fill;
  logic [SW-1:0]      free_idx;
  logic               free_any;
  logic [VW-1:0]      unl_vol;
  logic [PW-1:0]      in_price_c;
  logic [ID_BITS-1:0] nid_inc;

  lobm_level_store #(
    .DEPTH (LD),
    .AW    (LW),
    .DW    (LEW)
  ) u_levels (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (lvl_busy),
    .wr_en   (lvl_we),
    .wr_addr (lvl_wa),
    .wr_data (lvl_wd),
    .rd_addr (lvl_ra),
    .rd_data (lvl_rd_raw)
  );

  assign lq = level_t'(lvl_rd_raw);

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_ra];
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit_c   = out_free &&
                    ((state_r == ST_C_EM) || (state_r == ST_C_MISS) ||
                     (state_r == ST_M_TRD) || (state_r == ST_P_EM) ||
                     (state_r == ST_P_DROP));
  assign bp       = (side_r == lobm_pkg::SIDE_BUY) ? best_ask_r : best_bid_r;
  assign no_cross = (bp == '0) ||
                    ((side_r == lobm_pkg::SIDE_BUY) ? (bp > price_r) : (bp < price_r));
  assign fill     = (sd_r.qty < rem_r) ? sd_r.qty : rem_r;
  assign unl_vol  = (lq.vol >= VW'(sd_r.qty)) ? (lq.vol - VW'(sd_r.qty)) : '0;
  assign nid_inc  = next_id_r + ID_BITS'(1);

  always_comb begin
    if (in_limit_price == '0) begin
      in_price_c = PW'(1);
    end else if (int'(in_limit_price) > PRICE_LEVELS - 1) begin
      in_price_c = PW'(PRICE_LEVELS - 1);
    end else begin
      in_price_c = PW'(in_limit_price);
    end
  end

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  // memory port steering
  always_comb begin
    slot_we = 1'b0;
    slot_wa = u_s_r;
    slot_wd = sd_r;
    slot_ra = scan_r;
    lvl_we  = 1'b0;
    lvl_wa  = l_r;
    lvl_wd  = ld_r;
    lvl_ra  = l_r;
    unique case (state_r)
      ST_M_CHK: lvl_ra = lvl_idx(~side_r, bp);
      ST_M_LV:  slot_ra = lq.head;
      ST_M_TRD: begin
        if (out_free && (fill < sd_r.qty)) begin
          slot_we     = 1'b1;
          slot_wd.qty = sd_r.qty - fill;
          lvl_we      = 1'b1;
          lvl_wd.vol  = ld_r.vol - VW'(fill);
        end
      end
      ST_U_RD: lvl_ra = lvl_idx(sd_r.side, sd_r.price);
      ST_U_L: begin
        lvl_we      = 1'b1;
        lvl_wd.head = (lq.head == u_s_r) ? sd_r.nxt : lq.head;
        lvl_wd.tail = (lq.tail == u_s_r) ? sd_r.prv : lq.tail;
        lvl_wd.vol  = unl_vol;
        slot_ra     = sd_r.prv;
      end
      ST_U_PV: begin
        slot_we     = 1'b1;
        slot_wa     = sd_r.prv;
        slot_wd     = slot_q;
        slot_wd.nxt = sd_r.nxt;
      end
      ST_U_NXRD: slot_ra = sd_r.nxt;
      ST_U_NX: begin
        slot_we     = 1'b1;
        slot_wa     = sd_r.nxt;
        slot_wd     = slot_q;
        slot_wd.prv = sd_r.prv;
      end
      ST_RS_RD:  lvl_ra = lvl_idx(rs_side_r, rs_p_r);
      ST_P_FREE: lvl_ra = lvl_idx(side_r, price_r);
      ST_P_L: begin
        slot_we       = 1'b1;
        slot_wd.id    = id_r;
        slot_wd.qty   = rem_r;
        slot_wd.price = price_r;
        slot_wd.side  = side_r;
        slot_wd.nxt   = u_s_r;
        slot_wd.prv   = (lq.vol == '0) ? u_s_r : lq.tail;
        lvl_we        = 1'b1;
        lvl_wd.head   = (lq.vol == '0) ? u_s_r : lq.head;
        lvl_wd.tail   = u_s_r;
        lvl_wd.vol    = lq.vol + VW'(rem_r);
        slot_ra       = lq.tail;
      end
      ST_P_T: begin
        slot_we     = 1'b1;
        slot_wa     = t_r;
        slot_wd     = slot_q;
        slot_wd.nxt = u_s_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_id_r   <= ID_BITS'(1);
      valid_r     <= '0;
      best_bid_r  <= '0;
      best_ask_r  <= '0;
      out_valid_r <= 1'b0;
      ret_match_r <= 1'b0;
    end else begin
      if (emit_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            side_r  <= in_side;
            price_r <= in_price_c;
            rem_r   <= in_quantity;
            cid_r   <= in_cancel_id;
            id_r    <= next_id_r;
            scan_r  <= '0;
            if (in_kind == lobm_pkg::KIND_CANCEL) begin
              state_r <= ST_C_RD;
            end else if (in_quantity != '0) begin
              next_id_r <= (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
              state_r   <= ST_M_CHK;
            end
          end
        end
        ST_C_RD: state_r <= ST_C_CK;
        ST_C_CK: begin
          if (valid_r[scan_r] && (CW'(slot_q.id) == CW'(cid_r))) begin
            sd_r    <= slot_q;
            u_s_r   <= scan_r;
            state_r <= ST_C_EM;
          end else if (scan_r == SW'(ORDER_SLOTS - 1)) begin
            state_r <= ST_C_MISS;
          end else begin
            scan_r  <= scan_r + SW'(1);
            state_r <= ST_C_RD;
          end
        end
        ST_C_EM: begin
          if (out_free) begin
            out_ev_r    <= lobm_pkg::EV_CANCELLED;
            out_taker_r <= cid_r;
            out_maker_r <= '0;
            out_price_r <= PXW'(sd_r.price);
            out_qty_r   <= sd_r.qty;
            out_last_r  <= 1'b1;
            ret_match_r <= 1'b0;
            state_r     <= ST_U_RD;
          end
        end
        ST_C_MISS: begin
          if (out_free) begin
            out_ev_r    <= lobm_pkg::EV_UNKNOWN;
            out_taker_r <= cid_r;
            out_maker_r <= '0;
            out_price_r <= '0;
            out_qty_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_M_CHK: begin
          l_r     <= lvl_idx(~side_r, bp);
          state_r <= no_cross ? ST_P_FREE : ST_M_LV;
        end
        ST_M_LV: begin
          ld_r    <= lq;
          u_s_r   <= lq.head;
          state_r <= (lq.vol == '0) ? ST_P_FREE : ST_M_SL;
        end
        ST_M_SL: begin
          sd_r    <= slot_q;
          state_r <= ST_M_TRD;
        end
        ST_M_TRD: begin
          if (out_free) begin
            out_ev_r    <= lobm_pkg::EV_TRADE;
            out_taker_r <= OW'(id_r);
            out_maker_r <= OW'(sd_r.id);
            out_price_r <= PXW'(bp);
            out_qty_r   <= fill;
            out_last_r  <= (fill == rem_r);
            rem_r       <= rem_r - fill;
            if (fill >= sd_r.qty) begin
              ret_match_r <= (fill != rem_r);
              state_r     <= ST_U_RD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_U_RD: begin
          l_r     <= lvl_idx(sd_r.side, sd_r.price);
          state_r <= ST_U_L;
        end
        ST_U_L: begin
          tail_is_r        <= (lq.tail == u_s_r);
          vol_zero_r       <= (unl_vol == '0);
          valid_r[u_s_r]   <= 1'b0;
          if (lq.head != u_s_r) begin
            state_r <= ST_U_PV;
          end else if (lq.tail != u_s_r) begin
            state_r <= ST_U_NXRD;
          end else begin
            state_r <= ST_U_BEST;
          end
        end
        ST_U_PV:   state_r <= tail_is_r ? ST_U_BEST : ST_U_NXRD;
        ST_U_NXRD: state_r <= ST_U_NX;
        ST_U_NX:   state_r <= ST_U_BEST;
        ST_U_BEST: begin
          rs_side_r <= sd_r.side;
          rs_p_r    <= sd_r.price;
          if (vol_zero_r && (sd_r.side == lobm_pkg::SIDE_BUY) &&
              (best_bid_r == sd_r.price)) begin
            state_r <= ST_RS_RD;
          end else if (vol_zero_r && (sd_r.side == lobm_pkg::SIDE_SELL) &&
                       (best_ask_r == sd_r.price)) begin
            state_r <= ST_RS_RD;
          end else begin
            state_r <= ret_match_r ? ST_M_CHK : ST_IDLE;
          end
        end
        ST_RS_RD: state_r <= ST_RS_CHK;
        ST_RS_CHK: begin
          if (lq.vol != '0) begin
            if (rs_side_r == lobm_pkg::SIDE_BUY) best_bid_r <= rs_p_r;
            else                                 best_ask_r <= rs_p_r;
            state_r <= ret_match_r ? ST_M_CHK : ST_IDLE;
          end else if ((rs_side_r == lobm_pkg::SIDE_BUY) ? (rs_p_r == PW'(1))
                       : (rs_p_r == PW'(PRICE_LEVELS - 1))) begin
            if (rs_side_r == lobm_pkg::SIDE_BUY) best_bid_r <= '0;
            else                                 best_ask_r <= '0;
            state_r <= ret_match_r ? ST_M_CHK : ST_IDLE;
          end else begin
            rs_p_r  <= (rs_side_r == lobm_pkg::SIDE_BUY) ? (rs_p_r - PW'(1))
                                                        : (rs_p_r + PW'(1));
            state_r <= ST_RS_RD;
          end
        end
        ST_P_FREE: begin
          l_r     <= lvl_idx(side_r, price_r);
          u_s_r   <= free_idx;
          state_r <= free_any ? ST_P_L : ST_P_DROP;
        end
        ST_P_L: begin
          t_r            <= lq.tail;
          valid_r[u_s_r] <= 1'b1;
          if (side_r == lobm_pkg::SIDE_BUY) begin
            if ((best_bid_r == '0) || (price_r > best_bid_r)) best_bid_r <= price_r;
          end else begin
            if ((best_ask_r == '0) || (price_r < best_ask_r)) best_ask_r <= price_r;
          end
          state_r <= (lq.vol == '0) ? ST_P_EM : ST_P_T;
        end
        ST_P_T: state_r <= ST_P_EM;
        ST_P_EM, ST_P_DROP: begin
          if (out_free) begin
            out_ev_r    <= (state_r == ST_P_EM) ? lobm_pkg::EV_RESTED
                                                : lobm_pkg::EV_DROPPED;
            out_taker_r <= OW'(id_r);
            out_maker_r <= '0;
            out_price_r <= PXW'(price_r);
            out_qty_r   <= rem_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE) && !lvl_busy;
  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_taker_id     = out_taker_r;
  assign out_maker_id     = out_maker_r;
  assign out_price_out    = out_price_r;
  assign out_quantity_out = out_qty_r;
  assign out_last         = out_last_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_busy |-> !in_ready) else $error("input taken during level clear");

  a_book_not_crossed: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (best_bid_r != '0) && (best_ask_r != '0))
      |-> (best_bid_r < best_ask_r)) else $error("book crossed at rest");

  a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0) else $error("next id is zero");

  a_trade_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_M_TRD) |-> (rem_r != '0)) else $error("trade with no remainder");

endmodule
